>>> rtl/aes_pkg.sv
package aes_pkg;

  localparam int NumRows = 15;

  typedef enum logic [2:0] {
    REG_KEY_255_192 = 3'd0,
    REG_KEY_191_128 = 3'd1,
    REG_KEY_127_64  = 3'd2,
    REG_KEY_63_0    = 3'd3,
    REG_KEY_SIZE    = 3'd4,
    REG_MODE        = 3'd5,
    REG_CTR_HIGH    = 3'd6,
    REG_CTR_LOW     = 3'd7
  } reg_idx_t;

  localparam logic [1:0] MODE_ENC = 2'd0;
  localparam logic [1:0] MODE_DEC = 2'd1;
  localparam logic [1:0] MODE_CTR = 2'd2;

  localparam logic [1:0] KS_128 = 2'd0;
  localparam logic [1:0] KS_192 = 2'd1;

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] REDUCE     = 8'h1B;
  localparam logic [7:0] SBOX_ADD   = 8'h63;
  localparam logic [7:0] ISBOX_ADD  = 8'h05;

  typedef struct packed {
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic        final_block;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic [31:0] next_counter;
    logic        final_result;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load_in;
    logic       init;
    logic       round;
    logic       last;
    logic       fin;
    logic       exp_step;
    logic [5:0] widx;
    logic [2:0] jm;
    logic [3:0] ridx;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] key_size;
    logic [1:0] mode;
    logic       key_wr;
    logic       out_free;
  } dp_stat_t;

  function automatic logic [3:0] rounds_of(input logic [1:0] ks);
    logic [3:0] nr;
    case (ks)
      KS_128:  nr = 4'd10;
      KS_192:  nr = 4'd12;
      default: nr = 4'd14;
    endcase
    return nr;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? REDUCE : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    return p;
  endfunction

  // Inverse as a^254; zero maps to zero.
  function automatic logic [7:0] ginv(input logic [7:0] a);
    logic [7:0] r;
    logic [7:0] sq;
    r  = 8'h01;
    sq = a;
    for (int k = 1; k <= 7; k++) begin
      sq = gmul(sq, sq);
      r  = gmul(r, sq);
    end
    return r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] b, input int n);
    logic [15:0] t;
    t = {b, b} << n;
    return t[15:8];
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] b;
    b = ginv(x);
    return b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ SBOX_ADD;
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] y);
    logic [7:0] b;
    b = rotl8(y, 1) ^ rotl8(y, 3) ^ rotl8(y, 6) ^ ISBOX_ADD;
    return ginv(b);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] t);
    return {sbox(t[31:24]), sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0])};
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int i = 0; i < 16; i++) begin
      t[8*i +: 8] = inv ? inv_sbox(s[8*i +: 8]) : sbox(s[8*i +: 8]);
    end
    return t;
  endfunction

  // Byte i is s[127-8i -: 8]; byte index is row + 4*column.
  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int row = 0; row < 4; row++) begin
      for (int c = 0; c < 4; c++) begin
        if (inv) begin
          t[127-8*(row+4*((c+row)&3)) -: 8] = s[127-8*(row+4*c) -: 8];
        end else begin
          t[127-8*(row+4*c) -: 8] = s[127-8*(row+4*((c+row)&3)) -: 8];
        end
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      if (inv) begin
        t[127-32*c -: 8] = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9);
        t[119-32*c -: 8] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13);
        t[111-32*c -: 8] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11);
        t[103-32*c -: 8] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9) ^ gmul(a3, 8'd14);
      end else begin
        t[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        t[119-32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        t[111-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        t[103-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    return t;
  endfunction

endpackage

>>> rtl/aes_ctrl.sv
module aes_ctrl
  import aes_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXPAND,
    S_LOAD,
    S_INIT,
    S_ROUND,
    S_FIN
  } state_t;

  state_t     state;
  logic [5:0] widx;
  logic [2:0] jm;
  logic [3:0] ridx;
  logic [3:0] rcnt;

  logic [3:0] nr;
  logic [3:0] nk;
  logic [5:0] last_w;
  logic       dec;
  logic [3:0] ridx_step;

  assign nr        = rounds_of(stat.key_size);
  assign nk        = nr - 4'd6;
  assign last_w    = {nr, 2'b11};  // 4*(nr+1)-1
  assign dec       = (stat.mode == MODE_DEC);
  assign ridx_step = dec ? ridx - 4'd1 : ridx + 4'd1;

  assign in_ready = (state == S_IDLE) && !stat.key_wr;

  always_comb begin
    cmd          = '0;
    cmd.load_in  = in_ready && in_valid;
    cmd.init     = (state == S_INIT);
    cmd.round    = (state == S_ROUND);
    cmd.last     = (rcnt == nr);
    cmd.fin      = (state == S_FIN) && stat.out_free;
    cmd.exp_step = (state == S_EXPAND) && !stat.key_wr;
    cmd.widx     = widx;
    cmd.jm       = jm;
    cmd.ridx     = ridx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      widx  <= '0;
      jm    <= '0;
      ridx  <= '0;
      rcnt  <= '0;
    end else if (stat.key_wr) begin
      state <= S_EXPAND;
      widx  <= '0;
      jm    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_LOAD;
            ridx  <= dec ? nr : 4'd0;
          end
        end
        S_EXPAND: begin
          widx <= widx + 6'd1;
          jm   <= ({1'b0, jm} == nk - 4'd1) ? 3'd0 : jm + 3'd1;
          if (widx == last_w) state <= S_IDLE;
        end
        S_LOAD: begin
          ridx  <= ridx_step;
          state <= S_INIT;
        end
        S_INIT: begin
          ridx  <= ridx_step;
          rcnt  <= 4'd1;
          state <= S_ROUND;
        end
        S_ROUND: begin
          ridx <= ridx_step;
          rcnt <= rcnt + 4'd1;
          if (rcnt == nr) state <= S_FIN;
        end
        S_FIN: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/aes_dp.sv
module aes_dp
  import aes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat
);

  logic [63:0]  key_regs [4];
  logic [1:0]   key_size;
  logic [1:0]   mode;
  logic [63:0]  ctr_high;
  logic [63:0]  ctr_low;
  logic [31:0]  counter_word;

  logic [63:0]  rk_hi_mem [NumRows];
  logic [63:0]  rk_lo_mem [NumRows];
  logic [63:0]  rk_hi;
  logic [63:0]  rk_lo;

  logic [31:0]  win [8];
  logic [7:0]   rcon;

  logic [127:0] blk;
  logic [127:0] data_q;
  logic         final_q;
  logic [127:0] s;

  logic         is_ctr;
  logic         is_dec;
  logic [3:0]   nk;
  logic [31:0]  key_word;
  logic [31:0]  older;
  logic [31:0]  new_word;
  logic         at_key;
  logic [127:0] round_next;
  logic [127:0] rk;
  logic [127:0] t0;
  logic [127:0] t1;
  logic [127:0] t2;
  logic [127:0] result;

  assign is_ctr = (mode == MODE_CTR);
  assign is_dec = (mode == MODE_DEC);
  assign nk     = rounds_of(key_size) - 4'd6;

  assign stat.key_size = key_size;
  assign stat.mode     = mode;
  assign stat.key_wr   = cfg_valid && (cfg_index <= REG_KEY_SIZE);
  assign stat.out_free = !out_valid || out_ready;

  // Configuration registers and the running counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) key_regs[i] <= '0;
      key_size     <= '0;
      mode         <= '0;
      ctr_high     <= '0;
      ctr_low      <= '0;
      counter_word <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_KEY_255_192, REG_KEY_191_128, REG_KEY_127_64, REG_KEY_63_0:
            key_regs[cfg_index[1:0]] <= cfg_data;
          REG_KEY_SIZE: key_size <= cfg_data[1:0];
          REG_MODE:     mode     <= cfg_data[1:0];
          REG_CTR_HIGH: begin
            ctr_high     <= cfg_data;
            counter_word <= ctr_low[31:0];
          end
          REG_CTR_LOW: begin
            ctr_low      <= cfg_data;
            counter_word <= cfg_data[31:0];
          end
          default: ;
        endcase
      end else if (cmd.fin && is_ctr) begin
        counter_word <= counter_word + 32'd1;
      end
    end
  end

  // Key expansion: one schedule word per step, window of the last eight words.
  always_comb begin
    key_word = cmd.widx[0] ? key_regs[cmd.widx[2:1]][31:0] : key_regs[cmd.widx[2:1]][63:32];
    case (nk)
      4'd4:    older = win[4];
      4'd6:    older = win[2];
      default: older = win[0];
    endcase
    at_key = ({2'b00, nk} > cmd.widx);
    if (at_key) begin
      new_word = key_word;
    end else if (cmd.jm == 3'd0) begin
      new_word = older ^ sub_word({win[7][23:0], win[7][31:24]}) ^ {rcon, 24'h0};
    end else if (nk == 4'd8 && cmd.jm == 3'd4) begin
      new_word = older ^ sub_word(win[7]);
    end else begin
      new_word = older ^ win[7];
    end
  end

  always_ff @(posedge clk) begin
    if (stat.key_wr) begin
      rcon <= RCON_FIRST;
    end else if (cmd.exp_step) begin
      for (int i = 0; i < 7; i++) win[i] <= win[i+1];
      win[7] <= new_word;
      if (!at_key && cmd.jm == 3'd0) rcon <= xtime(rcon);
    end
  end

  // Round key store, one bank per half of a round key.
  always_ff @(posedge clk) begin
    if (cmd.exp_step && cmd.widx[0]) begin
      if (cmd.widx[1]) rk_lo_mem[cmd.widx[5:2]] <= {win[7], new_word};
      else             rk_hi_mem[cmd.widx[5:2]] <= {win[7], new_word};
    end
    rk_hi <= rk_hi_mem[cmd.ridx];
    rk_lo <= rk_lo_mem[cmd.ridx];
  end

  // Round datapath.
  always_comb begin
    rk = {rk_hi, rk_lo};
    if (is_dec) begin
      t0 = sub_bytes(shift_rows(s, 1'b1), 1'b1) ^ rk;
      round_next = cmd.last ? t0 : mix_columns(t0, 1'b1);
      t1 = '0;
      t2 = '0;
    end else begin
      t0 = '0;
      t1 = shift_rows(sub_bytes(s, 1'b0), 1'b0);
      t2 = cmd.last ? t1 : mix_columns(t1, 1'b0);
      round_next = t2 ^ rk;
    end
    result = is_ctr ? (s ^ data_q) : s;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      blk     <= is_ctr ? {ctr_high, ctr_low[63:32], counter_word}
                        : {in_data.data_high, in_data.data_low};
      data_q  <= {in_data.data_high, in_data.data_low};
      final_q <= in_data.final_block;
    end
    if (cmd.init) begin
      s <= blk ^ rk;
    end else if (cmd.round) begin
      s <= round_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_data.result_high  <= result[127:64];
      out_data.result_low   <= result[63:0];
      out_data.next_counter <= is_ctr ? counter_word + 32'd1 : counter_word;
      out_data.final_result <= final_q;
    end
  end

endmodule

>>> rtl/aes_block_and_ctr_engine.sv
// AES engine for 128, 192 and 256 bit keys with block encrypt, block decrypt
// and counter mode.
// Channels: the input channel (in_valid, in_ready, in_data) carries one
// 128-bit block per transfer; the output channel (out_valid, out_ready,
// out_data) returns one result per block, in order. The configuration
// channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes registers 0..7
// and is always ready; the user must write it only while the engine is idle,
// which the block itself does not enforce. A key word or key size write starts
// an expansion of 44, 52 or 60 schedule words, one word per cycle; no block is
// taken until it is done. A block is registered at its transfer and then goes
// through the load, initial key addition and Nr round steps; its last step loads
// the output register. The shared round unit does one round per cycle, fed by a
// round key store with a registered read, so one block is in flight at a time
// and the next transfer can follow in the cycle after the result is loaded.
// Reset clears the configuration, the counter and the control state; the
// round key store holds nothing valid until a key is written.
// When the receiver stalls, a finished result waits in the output register
// while the next block is already accepted and processed; that block then
// waits in its last step until the output register frees up.
module aes_block_and_ctr_engine
  import aes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Register writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  aes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  aes_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

>>> tb/aes_block_and_ctr_engine_test.sv
module aes_block_and_ctr_engine_test;
  import aes_pkg::*;

  // Codes that the package leaves unnamed. Key size three behaves as a 256-bit
  // key, and mode three behaves as block encryption.
  localparam logic [1:0] KS_256      = 2'd2;
  localparam logic [1:0] KS_SPARE    = 2'd3;
  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam int         KEY_SETTLE  = 70;  // longest key expansion plus margin
  localparam int         TAIL_CYCLES = 24;  // longest block latency plus margin

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  aes_block_and_ctr_engine DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Blocks waiting to be driven, and the results the cipher model predicts for
  // blocks that have already been transferred into the engine.
  in_item_t  block_queue[$];
  out_item_t cipher_results[$];
  int        error_count = 0;
  bit        calm = 0;  // when set, neither side inserts gaps

  // Shadow copy of the engine's configuration and counter.
  logic [63:0]  key_word[4];
  logic [1:0]   key_size_sh;
  logic [1:0]   mode_sh;
  logic [63:0]  ctr_high_sh;
  logic [63:0]  ctr_low_sh;
  logic [31:0]  ctr_word;
  logic [127:0] round_key[15];
  int           num_rounds;

  // Substitution tables, built once from the field arithmetic.
  logic [7:0] fwd_sub[256];
  logic [7:0] rev_sub[256];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // GF(2^8) product with the AES reduction polynomial.
  function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] rot_byte(input logic [7:0] b, input int n);
    return (b << n) | (b >> (8 - n));
  endfunction

  function automatic void build_sub_tables();
    logic [7:0] inv;
    logic [7:0] s;
    for (int x = 0; x < 256; x++) begin
      // The inverse is x^254, which also sends zero to zero.
      inv = (x == 0) ? 8'h00 : 8'h01;
      if (x != 0) begin
        for (int k = 0; k < 254; k++) inv = gf_mult(inv, x[7:0]);
      end
      s = inv ^ rot_byte(inv, 1) ^ rot_byte(inv, 2) ^ rot_byte(inv, 3) ^ rot_byte(inv, 4)
          ^ 8'h63;
      fwd_sub[x] = s;
      rev_sub[s] = x[7:0];
    end
  endfunction

  function automatic logic [31:0] sub_word32(input logic [31:0] w);
    return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
  endfunction

  // Rebuilds the round key schedule from the shadow key words and key size.
  function automatic void expand_schedule();
    logic [31:0] w[60];
    logic [31:0] t;
    logic [7:0]  rc;
    int          nk;
    num_rounds = (key_size_sh == KS_SPARE) ? 14 : 10 + 2 * key_size_sh;
    nk = num_rounds - 6;
    rc = 8'h01;
    for (int i = 0; i < nk; i++) begin
      w[i] = i[0] ? key_word[i / 2][31:0] : key_word[i / 2][63:32];
    end
    for (int i = nk; i < 4 * (num_rounds + 1); i++) begin
      t = w[i - 1];
      if (i % nk == 0) begin
        t = sub_word32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_mult(rc, 8'h02);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_word32(t);
      end
      w[i] = w[i - nk] ^ t;
    end
    for (int r = 0; r <= num_rounds; r++) begin
      round_key[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
    end
  endfunction

  // One block through the cipher. Byte i sits at bits 127-8i and is row i%4 of
  // column i/4.
  function automatic logic [127:0] cipher_block(input logic [127:0] blk, input bit decrypt);
    logic [7:0] s[16];
    logic [7:0] t[16];
    logic [127:0] v;
    int r;
    v = blk ^ round_key[decrypt ? num_rounds : 0];
    for (int i = 0; i < 16; i++) s[i] = v[127 - 8 * i -: 8];
    for (int step = 1; step <= num_rounds; step++) begin
      r = decrypt ? num_rounds - step : step;
      for (int row = 0; row < 4; row++) begin
        for (int c = 0; c < 4; c++) begin
          if (decrypt) t[row + 4 * ((c + row) & 3)] = s[row + 4 * c];
          else t[row + 4 * c] = s[row + 4 * ((c + row) & 3)];
        end
      end
      for (int i = 0; i < 16; i++) s[i] = decrypt ? rev_sub[t[i]] : fwd_sub[t[i]];
      // Decryption adds the round key before the column mix, encryption after.
      if (decrypt) begin
        for (int i = 0; i < 16; i++) s[i] ^= round_key[r][127 - 8 * i -: 8];
      end
      if (step < num_rounds) begin
        for (int c = 0; c < 4; c++) begin
          for (int i = 0; i < 4; i++) t[i] = s[4 * c + i];
          for (int i = 0; i < 4; i++) begin
            if (decrypt) begin
              s[4 * c + i] = gf_mult(t[i], 8'd14) ^ gf_mult(t[(i + 1) & 3], 8'd11)
                           ^ gf_mult(t[(i + 2) & 3], 8'd13) ^ gf_mult(t[(i + 3) & 3], 8'd9);
            end else begin
              s[4 * c + i] = gf_mult(t[i], 8'd2) ^ gf_mult(t[(i + 1) & 3], 8'd3)
                           ^ t[(i + 2) & 3] ^ t[(i + 3) & 3];
            end
          end
        end
      end
      if (!decrypt) begin
        for (int i = 0; i < 16; i++) s[i] ^= round_key[r][127 - 8 * i -: 8];
      end
    end
    for (int i = 0; i < 16; i++) v[127 - 8 * i -: 8] = s[i];
    return v;
  endfunction

  // Expected result of one transferred block; advances the counter in CTR mode.
  function automatic out_item_t predict_result(input in_item_t blk);
    out_item_t res;
    logic [127:0] v;
    if (mode_sh == MODE_CTR) begin
      v = cipher_block({ctr_high_sh, ctr_low_sh[63:32], ctr_word}, 0)
          ^ {blk.data_high, blk.data_low};
      ctr_word = ctr_word + 32'd1;
    end else begin
      v = cipher_block({blk.data_high, blk.data_low}, mode_sh == MODE_DEC);
    end
    res.result_high  = v[127:64];
    res.result_low   = v[63:0];
    res.next_counter = ctr_word;
    res.final_result = blk.final_block;
    return res;
  endfunction

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Driver: presents queued blocks at the falling edge and holds each one until
  // its transfer has been seen at the rising edge.
  logic in_xfer;
  int   in_gap = 0;
  int   out_gap = 0;

  always @(negedge clk) begin
    logic hold;
    hold = in_valid && !in_xfer;
    if (rst) begin
      hold = 0;
    end else if (!hold) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (block_queue.size() > 0) begin
        in_data <= block_queue.pop_front();
        hold = 1;
        in_gap = pick_gap();
      end
    end
    in_valid <= hold;

    // Receiver side stalls independently.
    if (out_gap > 0) begin
      out_ready <= 0;
      out_gap--;
    end else begin
      out_ready <= 1;
      out_gap = pick_gap();
    end
  end

  // Monitor: checks each result transfer against the oldest prediction, then
  // records the prediction for any block transferred at this edge.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      in_xfer <= 0;
    end else begin
      in_xfer <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (cipher_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual %h", $realtime, out_data);
          error_count++;
        end else begin
          want = cipher_results.pop_front();
          if (out_data.result_high !== want.result_high) begin
            $display("%0t: result_high expected %h actual %h", $realtime,
                     want.result_high, out_data.result_high);
            error_count++;
          end
          if (out_data.result_low !== want.result_low) begin
            $display("%0t: result_low expected %h actual %h", $realtime,
                     want.result_low, out_data.result_low);
            error_count++;
          end
          if (out_data.next_counter !== want.next_counter) begin
            $display("%0t: next_counter expected %h actual %h", $realtime,
                     want.next_counter, out_data.next_counter);
            error_count++;
          end
          if (out_data.final_result !== want.final_result) begin
            $display("%0t: final_result expected %b actual %b", $realtime,
                     want.final_result, out_data.final_result);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) cipher_results.push_back(predict_result(in_data));
    end
  end

  // Writes one register and mirrors it. A key or key size write is followed by
  // a pause long enough for the schedule to be rebuilt.
  task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_KEY_255_192, REG_KEY_191_128, REG_KEY_127_64, REG_KEY_63_0: begin
        key_word[idx] = value;
        expand_schedule();
      end
      REG_KEY_SIZE: begin
        key_size_sh = value[1:0];
        expand_schedule();
      end
      REG_MODE: mode_sh = value[1:0];
      REG_CTR_HIGH: begin
        ctr_high_sh = value;
        ctr_word = ctr_low_sh[31:0];
      end
      default: begin
        ctr_low_sh = value;
        ctr_word = value[31:0];
      end
    endcase
    @(negedge clk);
    cfg_valid <= 0;
    if (idx <= REG_KEY_SIZE) repeat (KEY_SETTLE) @(posedge clk);
  endtask

  task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3,
                          input logic [1:0] ks);
    write_reg(REG_KEY_255_192, k0);
    write_reg(REG_KEY_191_128, k1);
    write_reg(REG_KEY_127_64, k2);
    write_reg(REG_KEY_63_0, k3);
    write_reg(REG_KEY_SIZE, {62'd0, ks});
  endtask

  task automatic add_block(input logic [63:0] hi, input logic [63:0] lo, input logic fin);
    in_item_t blk;
    blk.data_high   = hi;
    blk.data_low    = lo;
    blk.final_block = fin;
    block_queue.push_back(blk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // The sender holds off until every queued block has gone through and every
  // result has come back, so the engine is idle afterwards.
  task automatic drain();
    @(posedge clk);
    while (block_queue.size() > 0 || in_valid || cipher_results.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic random_blocks(input int count);
    for (int i = 0; i < count; i++) add_block(rand64(), rand64(), $urandom_range(0, 7) == 0);
  endtask

  initial begin
    logic [1:0] ks;
    logic [1:0] md;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    cfg_valid = 0;
    cfg_index = REG_KEY_255_192;
    cfg_data = '0;
    build_sub_tables();
    foreach (key_word[i]) key_word[i] = '0;
    key_size_sh = KS_128;
    mode_sh = MODE_ENC;
    ctr_high_sh = '0;
    ctr_low_sh = '0;
    ctr_word = '0;
    expand_schedule();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed part: extremes of the data with each mode and key size.
    load_key('0, '0, '0, '0, KS_128);
    add_block('0, '0, 0);
    add_block('1, '1, 1);
    drain();
    load_key('1, '1, '1, '1, KS_128);
    add_block(64'h0011223344556677, 64'h8899AABBCCDDEEFF, 0);
    add_block('1, '0, 1);
    drain();
    load_key(64'h0001020304050607, 64'h08090A0B0C0D0E0F, 64'h1011121314151617,
             64'h18191A1B1C1D1E1F, KS_192);
    add_block(64'h0011223344556677, 64'h8899AABBCCDDEEFF, 0);
    drain();
    write_reg(REG_MODE, {62'd0, MODE_DEC});
    add_block('0, '1, 1);
    add_block(64'hDDA97CA4864CDFE0, 64'h6EAF70A0EC0D7191, 0);
    drain();
    write_reg(REG_KEY_SIZE, {62'd0, KS_256});
    add_block(64'h8EA2B7CA516745BF, 64'hEAFC49904B496089, 1);
    add_block('1, '1, 0);
    drain();
    // Key size three and mode three.
    write_reg(REG_KEY_SIZE, {62'd0, KS_SPARE});
    write_reg(REG_MODE, {62'd0, MODE_SPARE});
    add_block('0, '0, 0);
    add_block('1, '1, 1);
    drain();
    // Counter mode across the wrap of the low 32 bits.
    write_reg(REG_MODE, {62'd0, MODE_CTR});
    write_reg(REG_CTR_HIGH, '1);
    write_reg(REG_CTR_LOW, 64'hFFFFFFFF_FFFFFFFD);
    add_block('0, '0, 0);
    add_block('1, '1, 1);
    add_block('0, '1, 0);
    add_block(rand64(), rand64(), 1);
    drain();
    write_reg(REG_CTR_HIGH, '0);
    add_block('1, '0, 0);
    add_block('0, '0, 1);
    drain();

    // Random part: fresh settings per run, some runs without any idling.
    for (int phase = 0; phase < 14; phase++) begin
      calm = (phase % 5 == 2);
      ks = 2'($urandom_range(0, 3));
      md = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 2) != 0) load_key(rand64(), rand64(), rand64(), rand64(), ks);
      else write_reg(REG_KEY_SIZE, {62'd0, ks});
      if ($urandom_range(0, 3) == 0) md = MODE_CTR;
      write_reg(REG_MODE, {62'd0, md});
      if (md == MODE_CTR) begin
        write_reg(REG_CTR_HIGH, rand64());
        write_reg(REG_CTR_LOW, {$urandom, ($urandom_range(0, 1) ? 32'hFFFFFFF0 : 32'd0)
                                          | $urandom_range(0, 15)});
      end
      random_blocks(34);
      drain();
    end

    calm = 0;
    drain();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
